// ===== hw/rtl/stoc_pkg.sv =====
// Shared types and constants for the stepper tone oscillator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package stoc_pkg;

  localparam int NOW_W    = 32;
  localparam int PER_W    = 20;
  localparam int HALF_W   = PER_W - 1;
  localparam int HOLD_W   = 24;
  localparam int OPC_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;
  localparam int CNT_W    = $clog2(NOW_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NOW_W - 1);

  localparam logic [PER_W-1:0]  LIMIT_INTERVAL_RST = PER_W'(10000);
  localparam logic [HOLD_W-1:0] RELAY_HOLDOFF_RST  = HOLD_W'(500000);

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_HOLDOFF  = CFG_IDX_W'(1);

  typedef enum logic [OPC_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TONE,
    ST_EVAL_TONE,
    ST_DIV_CHK,
    ST_EVAL_CHK,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted input beat
    logic note_on;
    logic note_off;
    logic div_init;    // restart the remainder unit on the latched time
    logic div_step;    // one restoring step
    logic div_sel_chk; // divisor is the limit check interval
    logic eval_tone;
    logic eval_chk;
    logic out_load;    // copy the levels into the result register
  } stoc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tone_zero;
    logic intv_zero;
  } stoc_sts_t;

endpackage

// ===== hw/rtl/stoc_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on stoc_pkg for the field widths.
`timescale 1ns / 1ps

interface stoc_in_if
  import stoc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [NOW_W-1:0] now_us;
  logic             limit_low;
  logic [PER_W-1:0] note_period_us;

  modport source (output valid, opcode, now_us, limit_low, note_period_us, input ready);
  modport sink   (input valid, opcode, now_us, limit_low, note_period_us, output ready);
endinterface

interface stoc_out_if;
  logic valid;
  logic ready;
  logic step_level;
  logic dir_level;
  logic relay_level;
  logic motor_enable;

  modport source (output valid, step_level, dir_level, relay_level, motor_enable,
                  input ready);
  modport sink   (input valid, step_level, dir_level, relay_level, motor_enable,
                  output ready);
endinterface

// ===== hw/rtl/stoc_ctrl.sv =====
// Sequencing state machine of the stepper tone oscillator.
// Depends on stoc_pkg; drives the datapath through stoc_cmd_t.
`timescale 1ns / 1ps

module stoc_ctrl
  import stoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [OPC_W-1:0] in_opcode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  stoc_sts_t        sts,
  output stoc_cmd_t        cmd
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_TICK: begin
              state_nxt = sts.tone_zero ? ST_FINISH : ST_DIV_TONE;
            end
            OP_NOTE_ON: begin
              cmd.note_on = 1'b1;
              state_nxt   = ST_FINISH;
            end
            OP_NOTE_OFF: begin
              cmd.note_off = 1'b1;
              state_nxt    = ST_FINISH;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_DIV_TONE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EVAL_TONE;
        end
      end
      ST_EVAL_TONE: begin
        cmd.eval_tone = 1'b1;
        cnt_nxt       = '0;
        if (sts.intv_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV_CHK;
        end
      end
      ST_DIV_CHK: begin
        cmd.div_step    = 1'b1;
        cmd.div_sel_chk = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EVAL_CHK;
        end
      end
      ST_EVAL_CHK: begin
        cmd.eval_chk = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // A tick with a running tone always starts the tone division.
  a_tick_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_TICK && !sts.tone_zero)
      |=> state_r == ST_DIV_TONE)
    else $error("tick did not start the tone division");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_valid_r && !out_ready))
    else $error("result register overwritten while stalled");

  // The step counter advances by one on every division step.
  a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && cnt_r != CNT_LAST) |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("division step counter skipped");

  // No input is taken while the remainder unit is busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.div_step)
    else $error("input accepted during division");

endmodule

// ===== hw/rtl/stoc_dp.sv =====
// Datapath of the stepper tone oscillator: configuration, oscillator state,
// a shared restoring remainder unit and the result register. Depends on stoc_pkg.
`timescale 1ns / 1ps

module stoc_dp
  import stoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic [NOW_W-1:0]     in_now_us,
  input  logic                 in_limit_low,
  input  logic [PER_W-1:0]     in_note_period_us,
  input  stoc_cmd_t            cmd,
  output stoc_sts_t            sts,
  output logic                 step_level,
  output logic                 dir_level,
  output logic                 relay_level,
  output logic                 motor_enable
);

  logic [PER_W-1:0]  intv_r;
  logic [HOLD_W-1:0] holdoff_cfg_r;
  logic [PER_W-1:0]  tone_r;
  logic [HALF_W-1:0] half_r;
  logic              step_r, dir_r, phase_r, relay_r, enabled_r;
  logic [NOW_W-1:0]  holdoff_until_r;

  logic [NOW_W-1:0]  now_r;
  logic              low_r;
  logic [NOW_W-1:0]  shf_r;
  logic [PER_W-1:0]  rem_r, rem_nxt;

  logic              out_step_r, out_dir_r, out_relay_r, out_en_r;

  logic [PER_W-1:0]  dvsr;
  logic [PER_W:0]    rem_sh;
  logic [PER_W:0]    rem_sub;
  logic              tone_above, chk_above, holdoff_passed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r        <= LIMIT_INTERVAL_RST;
      holdoff_cfg_r <= RELAY_HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT_INTERVAL: intv_r        <= cfg_wdata[PER_W-1:0];
        CFG_RELAY_HOLDOFF:  holdoff_cfg_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // One restoring remainder step per cycle, dividend bits taken MSB first.
  assign dvsr    = cmd.div_sel_chk ? intv_r : tone_r;
  assign rem_sh  = {rem_r, shf_r[NOW_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign rem_nxt = (rem_sh >= {1'b0, dvsr}) ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_now_us;
      low_r <= in_limit_low;
      shf_r <= in_now_us;
      rem_r <= '0;
    end else if (cmd.div_init) begin
      shf_r <= now_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      shf_r <= {shf_r[NOW_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign tone_above     = rem_r > {1'b0, half_r};
  assign chk_above      = rem_r > {1'b0, intv_r[PER_W-1:1]};
  assign holdoff_passed = now_r > holdoff_until_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r          <= '0;
      half_r          <= '0;
      step_r          <= 1'b0;
      dir_r           <= 1'b0;
      phase_r         <= 1'b0;
      relay_r         <= 1'b0;
      holdoff_until_r <= '0;
      enabled_r       <= 1'b0;
    end else begin
      if (cmd.note_on) begin
        enabled_r       <= 1'b1;
        tone_r          <= in_note_period_us;
        half_r          <= in_note_period_us[PER_W-1:1];
        holdoff_until_r <= '0;
      end
      if (cmd.note_off) begin
        enabled_r       <= 1'b0;
        tone_r          <= '0;
        half_r          <= '0;
        phase_r         <= 1'b0;
        holdoff_until_r <= '0;
      end
      // Step follows the tone phase; a falling step edge flips direction.
      if (cmd.eval_tone && tone_above == step_r) begin
        step_r <= ~step_r;
        if (step_r) begin
          dir_r <= ~dir_r;
        end
      end
      // A rising edge of the check phase samples the limit switch.
      if (cmd.eval_chk && chk_above == phase_r) begin
        phase_r <= ~phase_r;
        if (!phase_r && holdoff_passed && low_r) begin
          relay_r         <= ~relay_r;
          holdoff_until_r <= now_r + {{(NOW_W-HOLD_W){1'b0}}, holdoff_cfg_r};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_step_r  <= step_r;
      out_dir_r   <= dir_r;
      out_relay_r <= relay_r;
      out_en_r    <= enabled_r;
    end
  end

  assign sts.tone_zero = (tone_r == '0);
  assign sts.intv_zero = (intv_r == '0);

  assign step_level   = out_step_r;
  assign dir_level    = out_dir_r;
  assign relay_level  = out_relay_r;
  assign motor_enable = out_en_r;

endmodule

// ===== hw/rtl/stepper_tone_oscillator_core.sv =====
// Stepper tone oscillator: beats of tick, note on and note off in, one level
// beat out per input beat. Top level; depends on stoc_pkg, stoc_if, stoc_ctrl, stoc_dp.
`timescale 1ns / 1ps
//
// Usage:
// The input channel in_bus carries an opcode with the current time, the limit
// switch level and a tone period. Every accepted beat produces exactly one
// beat on out_bus holding the step, direction, relay and enable levels after
// that beat has been applied.
// A note on or note off beat goes from acceptance straight to the final write.
// A tick with a running tone needs two 32-step remainder computations on one
// shared restoring unit (one dividend bit per cycle), against the tone period
// and then the check interval; a zero tone period skips both and a zero check
// interval the second. A new input beat is accepted only in the idle state
// after the result is written, never while a tick is still being divided.
// The result sits in an output register. While the receiver stalls, the block
// still accepts and works on the next beat and holds it only at the final
// write until the waiting result has been taken.
// Configuration writes take effect at the clock edge with cfg_we high and
// must only be issued while the block is idle.
// Reset (rst_n low, synchronous) clears all oscillator state and restores the
// default check interval of 10000 us and relay hold-off of 500000 us.

module stepper_tone_oscillator_core
  import stoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  stoc_in_if.sink              in_bus,
  stoc_out_if.source           out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Commands and status between the sequencer and the datapath.
  stoc_cmd_t cmd;
  stoc_sts_t sts;

  // The sequencer owns both handshakes and the order of datapath operations.
  stoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_opcode (in_bus.opcode),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds configuration, oscillator state, the remainder unit
  // and the registered result levels.
  stoc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_now_us         (in_bus.now_us),
    .in_limit_low      (in_bus.limit_low),
    .in_note_period_us (in_bus.note_period_us),
    .cmd               (cmd),
    .sts               (sts),
    .step_level        (out_bus.step_level),
    .dir_level         (out_bus.dir_level),
    .relay_level       (out_bus.relay_level),
    .motor_enable      (out_bus.motor_enable)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for stepper_tone_oscillator_core: a scoreboard class predicts the
// step, direction, relay and enable levels for every input beat and checks each result beat.
// Depends on stoc_pkg, the stoc_in_if/stoc_out_if interfaces and the core RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic step;
  logic dir;
  logic relay;
  logic enable;
} levels_t;

// Tracks the oscillator state, predicts levels per beat and compares result beats.
class tone_scoreboard;
  logic [19:0] check_interval;
  logic [23:0] relay_holdoff;
  logic [19:0] tone_period;
  logic [18:0] half_period;
  logic        step_q, dir_q, phase_q, relay_q, enabled_q;
  logic [31:0] holdoff_until;
  levels_t     expected_levels[$];
  int          beats, checked, failures, dir_flips, relay_flips;

  function new();
    check_interval = stoc_pkg::LIMIT_INTERVAL_RST;
    relay_holdoff  = stoc_pkg::RELAY_HOLDOFF_RST;
    tone_period    = '0;
    half_period    = '0;
    step_q         = 1'b0;
    dir_q          = 1'b0;
    phase_q        = 1'b0;
    relay_q        = 1'b0;
    enabled_q      = 1'b0;
    holdoff_until  = '0;
    beats          = 0;
    checked        = 0;
    failures       = 0;
    dir_flips      = 0;
    relay_flips    = 0;
  endfunction

  function void write_reg(logic [stoc_pkg::CFG_IDX_W-1:0] idx,
                          logic [stoc_pkg::CFG_DAT_W-1:0] val);
    if (idx == stoc_pkg::CFG_LIMIT_INTERVAL) begin
      check_interval = val[19:0];
    end else begin
      relay_holdoff = val;
    end
  endfunction

  function void note_beat(logic [1:0] op, logic [31:0] now, logic low, logic [19:0] per);
    logic [31:0] pos, cpos;
    logic        above, cabove;
    case (op)
      stoc_pkg::OP_TICK: begin
        if (tone_period != 0) begin
          pos   = now % {12'd0, tone_period};
          above = (pos > {13'd0, half_period});
          if (above == step_q) begin
            step_q = ~step_q;
            if (!step_q) begin
              dir_q = ~dir_q;
              dir_flips++;
            end
          end
          if (check_interval != 0) begin
            cpos   = now % {12'd0, check_interval};
            cabove = (cpos > {12'd0, check_interval >> 1});
            if (cabove == phase_q) begin
              phase_q = ~phase_q;
              if (phase_q && now > holdoff_until && low) begin
                relay_q       = ~relay_q;
                holdoff_until = now + {8'd0, relay_holdoff};
                relay_flips++;
              end
            end
          end
        end
      end
      stoc_pkg::OP_NOTE_ON: begin
        enabled_q     = 1'b1;
        tone_period   = per;
        half_period   = per[19:1];
        holdoff_until = '0;
      end
      stoc_pkg::OP_NOTE_OFF: begin
        enabled_q     = 1'b0;
        tone_period   = '0;
        half_period   = '0;
        phase_q       = 1'b0;
        holdoff_until = '0;
      end
      default: begin
      end
    endcase
    expected_levels.push_back('{step: step_q, dir: dir_q, relay: relay_q, enable: enabled_q});
    beats++;
  endfunction

  function void check_levels(levels_t got);
    levels_t want;
    if (expected_levels.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("tb: result beat with nothing expected: step %b dir %b relay %b en %b",
                 got.step, got.dir, got.relay, got.enable);
      end
      return;
    end
    want = expected_levels.pop_front();
    checked++;
    if (got.step !== want.step || got.dir !== want.dir ||
        got.relay !== want.relay || got.enable !== want.enable) begin
      failures++;
      if (failures <= 10) begin
        $display("tb: result %0d mismatch: step %b/%b dir %b/%b relay %b/%b en %b/%b (exp/got)",
                 checked, want.step, got.step, want.dir, got.dir,
                 want.relay, got.relay, want.enable, got.enable);
      end
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module tb;
  import stoc_pkg::*;

  // Opcode 3 is outside the enum; the block must treat it as a no-op.
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  // Cycles without any accepted beat before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus one tick and the final drain.
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_BEATS = 106;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  stoc_in_if  in_bus ();
  stoc_out_if out_bus ();

  stepper_tone_oscillator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tone_scoreboard sb;

  // When calm is set neither side inserts random idle cycles, so back-to-back beats occur.
  bit          calm;
  logic [31:0] now_t;
  int          cur_period;
  int          settings_used;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one input beat after a random gap and returns once it has been taken.
  // The predictor is updated at the acceptance edge, so it always runs ahead of the
  // result beats, which are written to the result register only after acceptance.
  task automatic send_beat(input logic [OPC_W-1:0] op, input logic [NOW_W-1:0] now,
                           input logic low, input logic [PER_W-1:0] per);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.opcode         <= op;
    in_bus.now_us         <= now;
    in_bus.limit_low      <= low;
    in_bus.note_period_us <= per;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_beat(op, now, low, per);
  endtask

  // Drops valid and waits until every predicted result beat has been checked.
  // Every beat produces a result, so an empty queue means the core is idle; extra
  // idle cycles let the handshake settle before any register write.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the enable is dropped only after the
  // second write so that it never sees two assignments in one step.
  task automatic write_regs(input logic [PER_W-1:0] interval, input logic [HOLD_W-1:0] holdoff);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIMIT_INTERVAL;
    cfg_wdata <= CFG_DAT_W'(interval);
    @(posedge clk);
    sb.write_reg(CFG_LIMIT_INTERVAL, CFG_DAT_W'(interval));
    cfg_index <= CFG_RELAY_HOLDOFF;
    cfg_wdata <= holdoff;
    @(posedge clk);
    sb.write_reg(CFG_RELAY_HOLDOFF, holdoff);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly ticks on a forward-running clock with steps sized to the
  // tone period or the check interval, so that step edges, direction reversals, check
  // phase edges and relay toggles all happen. Notes, stray times and the unused opcode
  // are mixed in as noise.
  task automatic random_beats(input int count);
    int          r, span, chk_span, per;
    logic [31:0] delta;
    chk_span = (sb.check_interval == 0) ? 1000 : int'(sb.check_interval) / 2 + 1;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 9))
          0:       per = 0;
          1:       per = 1;
          2:       per = 20'hFFFFF;
          3:       per = $urandom_range(0, 20'hFFFFF);
          default: per = $urandom_range(2, 400);
        endcase
        cur_period = per;
        send_beat(OP_NOTE_ON, $urandom, 1'($urandom_range(0, 1)), PER_W'(per));
      end else if (r < 9) begin
        cur_period = 0;
        send_beat(OP_NOTE_OFF, $urandom, 1'($urandom_range(0, 1)),
                  PER_W'($urandom_range(0, 20'hFFFFF)));
      end else if (r < 11) begin
        send_beat(OP_UNUSED, $urandom, 1'($urandom_range(0, 1)),
                  PER_W'($urandom_range(0, 20'hFFFFF)));
      end else if (r < 15) begin
        send_beat(OP_TICK, $urandom, 1'($urandom_range(0, 1)),
                  PER_W'($urandom_range(0, 20'hFFFFF)));
      end else begin
        span = (cur_period == 0) ? 1000 : cur_period / 3 + 1;
        if ($urandom_range(0, 2) == 0) begin
          delta = $urandom_range(1, chk_span);
        end else begin
          delta = $urandom_range(1, span);
        end
        now_t = now_t + delta;
        send_beat(OP_TICK, now_t, ($urandom_range(0, 3) != 0),
                  PER_W'($urandom_range(0, 20'hFFFFF)));
      end
    end
  endtask

  // Result side: random stalls per beat, plus one long hold-off partway through the
  // run while the sender keeps offering beats, so the core backs up and drops ready.
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!hold_done && sb.checked >= 200) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      sb.check_levels('{step: out_bus.step_level, dir: out_bus.dir_level,
                        relay: out_bus.relay_level, enable: out_bus.motor_enable});
    end
  end

  // Watchdog: any accepted beat on either channel counts as progress.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("tb: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    sb            = new();
    calm          = 1'b0;
    hold_done     = 1'b0;
    now_t         = '0;
    cur_period    = 0;
    settings_used = 1;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_bus.valid          <= 1'b0;
    in_bus.opcode         <= OP_TICK;
    in_bus.now_us         <= '0;
    in_bus.limit_low      <= 1'b0;
    in_bus.note_period_us <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset defaults (interval 10000 us, hold-off 500000 us).
    // A tick before any note leaves everything alone, as does the unused opcode.
    send_beat(OP_TICK, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
    send_beat(OP_UNUSED, 32'hA5A5_5A5A, 1'b1, 20'h5A5A5);
    // A note with a zero period enables the driver but ticks still do nothing.
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd0);
    send_beat(OP_TICK, 32'd12345, 1'b1, 20'd0);
    // Longest tone period, sampled at time zero, just past half a period and at 32'hFFFF_FFFF.
    send_beat(OP_NOTE_ON, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
    send_beat(OP_TICK, 32'd0, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd524288, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'hFFFF_FFFF, 1'b0, 20'd0);
    // Period of one: the tone position is always zero, so the step level stays high.
    // These ticks walk the check phase: the first rising edge toggles the relay, the
    // next one falls inside the hold-off, a later one is past it, and the last comes
    // inside the new hold-off with the switch reading high.
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd1);
    send_beat(OP_TICK, 32'd5, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd6000, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd10001, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd16000, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd520001, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd526000, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'd530001, 1'b0, 20'd0);
    // A new note clears the hold-off. A rising check edge just below the 32-bit wrap
    // toggles the relay with a wrapped hold-off sum, and the rising edge after the wrap
    // must then fail the unsigned compare.
    send_beat(OP_NOTE_ON, 32'h1234_5678, 1'b1, 20'd3);
    send_beat(OP_TICK, 32'hFFFF_FFF0, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'hFFFF_E768, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'hFFFF_FFFB, 1'b1, 20'd0);
    send_beat(OP_TICK, 32'h0000_0004, 1'b1, 20'd0);
    // Note off stops the tone; a following tick changes nothing.
    send_beat(OP_NOTE_OFF, 32'h0, 1'b0, 20'd0);
    send_beat(OP_TICK, 32'd100, 1'b1, 20'd0);
    send_beat(OP_UNUSED, 32'h5A5A_A5A5, 1'b0, 20'hA5A5A);

    // Random phases, each starting with a running tone; later ones use new register settings.
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd120);
    cur_period = 120;
    random_beats(PHASE_BEATS);

    // Small settings (interval 2, no hold-off), with no random idle cycles on either side.
    wait_idle();
    write_regs(20'd2, 24'd0);
    calm = 1'b1;
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd7);
    cur_period = 7;
    random_beats(PHASE_BEATS);

    // Largest settings.
    wait_idle();
    calm = 1'b0;
    write_regs(20'hFFFFF, 24'hFFFFFF);
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd300);
    cur_period = 300;
    random_beats(PHASE_BEATS);

    // Zero interval: limit sampling is skipped and the check phase is held.
    wait_idle();
    write_regs(20'd0, HOLD_W'($urandom_range(0, 24'hFFFFFF)));
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd50);
    cur_period = 50;
    random_beats(PHASE_BEATS);

    // Short interval and short hold-off so the relay toggles often.
    wait_idle();
    write_regs(PER_W'($urandom_range(1, 5000)), HOLD_W'($urandom_range(0, 20000)));
    send_beat(OP_NOTE_ON, 32'h0, 1'b0, 20'd90);
    cur_period = 90;
    random_beats(PHASE_BEATS);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.failures++;
      $display("tb: %0d expected result beats never arrived", sb.pending());
    end

    $display("tb: %0d beats sent under %0d register settings, %0d results checked",
             sb.beats, settings_used, sb.checked);
    $display("tb: predicted %0d direction reversals and %0d relay toggles, %0d failures",
             sb.dir_flips, sb.relay_flips, sb.failures);
    if (sb.failures == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== stepper_tone_oscillator_core.f =====
hw/rtl/stoc_pkg.sv
hw/rtl/stoc_if.sv
hw/rtl/stoc_ctrl.sv
hw/rtl/stoc_dp.sv
hw/rtl/stepper_tone_oscillator_core.sv
sim/tb.sv
